// ----- src/ate_pkg.sv -----
// ate_pkg: shared types, codes and widths for the array table engine.
// Used by ate_ctrl, ate_dp and array_table_engine_core; depends on nothing.
`timescale 1ns / 1ps

package ate_pkg;

  localparam int ATE_DEPTH = 64;
  localparam int OP_W      = 3;
  localparam int CNT_W     = 7;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 3;
  localparam int IDX_W     = 6;
  localparam int MCNT_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_START = 3'd0,
    OP_LOAD_VALUE = 3'd1,
    OP_UPDATE     = 3'd2,
    OP_DELETE     = 3'd3,
    OP_READ_ALL   = 3'd4,
    OP_SORT       = 3'd5,
    OP_SEARCH     = 3'd6,
    OP_INVALID    = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BADSIZE   = 3'd1,
    ST_NOINIT    = 3'd2,
    ST_BADINDEX  = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_BADOP     = 3'd5
  } status_t;

  // Output field selection for a result transaction
  typedef enum logic [2:0] {
    OSEL_PLAIN,  // status only
    OSEL_MISS,   // status and key, index 0
    OSEL_KEY,    // status, key and index i
    OSEL_READ,   // index i, stored value
    OSEL_MATCH   // index i, key, match count
  } osel_t;

  // Memory read address select
  typedef enum logic [1:0] {
    RSEL_I,
    RSEL_J,
    RSEL_J1
  } rsel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_EMIT,
    S_DEL_RD,
    S_DEL_CHK,
    S_SH_RD,
    S_SH_WR,
    S_RD_RD,
    S_RD_EM,
    S_SO_LDA,
    S_SO_A,
    S_SO_RD,
    S_SO_CMP,
    S_SC_RD,
    S_SC_CHK,
    S_SE_RD,
    S_SE_CHK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    load_start;
    logic    fill_wr;
    logic    upd_wr;
    logic    shift_wr;
    logic    sort_ld_a;
    logic    sort_step;
    logic    sort_wr_i;
    logic    shrink;
    logic    clr_i;
    logic    inc_i;
    logic    set_j_i;
    logic    set_j_i1;
    logic    inc_j;
    logic    clr_n;
    logic    cnt_step;
    logic    clr_k;
    logic    inc_k;
    logic    rd_en;
    rsel_t   rd_sel;
    logic    out_load;
    osel_t   osel;
    status_t ostat;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic count_ok;
    logic size_zero;
    logic size_lt2;
    logic fp_full;
    logic pos_bad;
    logic i_lt_size;
    logic i_last;
    logic i_more;
    logic j_lt_size;
    logic j1_lt_size;
    logic match;
    logic n_zero;
    logic k_last;
  } stat_t;

endpackage

// ----- src/ate_ctrl.sv -----
// ate_ctrl: command sequencer of the array table engine.
// Depends on ate_pkg; drives the cmd_t bundle into ate_dp.
`timescale 1ns / 1ps

module ate_ctrl
  import ate_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  out_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Next state and return state after an emitted result
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        state_nxt = S_EMIT;
        ret_nxt   = S_IDLE;
        if (st.op != OP_LOAD_START && st.op != OP_INVALID && !st.size_zero) begin
          unique case (st.op)
            OP_DELETE:   state_nxt = S_DEL_RD;
            OP_READ_ALL: state_nxt = S_RD_RD;
            OP_SORT:     if (!st.size_lt2) state_nxt = S_SO_LDA;
            OP_SEARCH:   state_nxt = S_SC_RD;
            default:     state_nxt = S_EMIT;
          endcase
        end
      end
      S_EMIT: if (!out_stall) state_nxt = ret_r;
      S_DEL_RD: begin
        if (st.i_lt_size) begin
          state_nxt = S_DEL_CHK;
        end else begin
          state_nxt = S_EMIT;
          ret_nxt   = S_IDLE;
        end
      end
      S_DEL_CHK: state_nxt = st.match ? S_SH_RD : S_DEL_RD;
      S_SH_RD: begin
        if (st.j1_lt_size) begin
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_EMIT;
          ret_nxt   = S_IDLE;
        end
      end
      S_SH_WR: state_nxt = S_SH_RD;
      S_RD_RD: state_nxt = S_RD_EM;
      S_RD_EM: begin
        state_nxt = S_EMIT;
        ret_nxt   = st.i_last ? S_IDLE : S_RD_RD;
      end
      S_SO_LDA: state_nxt = S_SO_A;
      S_SO_A:   state_nxt = S_SO_RD;
      S_SO_RD: begin
        if (st.j_lt_size) begin
          state_nxt = S_SO_CMP;
        end else if (st.i_more) begin
          state_nxt = S_SO_LDA;
        end else begin
          state_nxt = S_EMIT;
          ret_nxt   = S_IDLE;
        end
      end
      S_SO_CMP: state_nxt = S_SO_RD;
      S_SC_RD: begin
        if (st.i_lt_size) begin
          state_nxt = S_SC_CHK;
        end else if (st.n_zero) begin
          state_nxt = S_EMIT;
          ret_nxt   = S_IDLE;
        end else begin
          state_nxt = S_SE_RD;
        end
      end
      S_SC_CHK: state_nxt = S_SC_RD;
      S_SE_RD:  state_nxt = S_SE_CHK;
      S_SE_CHK: begin
        if (st.match) begin
          state_nxt = S_EMIT;
          ret_nxt   = st.k_last ? S_IDLE : S_SE_RD;
        end else begin
          state_nxt = S_SE_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RSEL_I;
    cmd.osel   = OSEL_PLAIN;
    cmd.ostat  = ST_OK;
    unique case (state_r)
      S_IDLE: cmd.capture = in_valid;
      S_DISPATCH: begin
        cmd.out_load = 1'b1;
        if (st.op == OP_LOAD_START) begin
          cmd.load_start = 1'b1;
          cmd.ostat      = st.count_ok ? ST_OK : ST_BADSIZE;
        end else if (st.op == OP_INVALID) begin
          cmd.ostat = ST_BADOP;
        end else if (st.size_zero) begin
          cmd.ostat = ST_NOINIT;
        end else begin
          unique case (st.op)
            OP_LOAD_VALUE: begin
              cmd.fill_wr = !st.fp_full;
              cmd.ostat   = st.fp_full ? ST_BADINDEX : ST_OK;
            end
            OP_UPDATE: begin
              cmd.upd_wr = !st.pos_bad;
              cmd.ostat  = st.pos_bad ? ST_BADINDEX : ST_OK;
            end
            OP_DELETE, OP_READ_ALL: begin
              cmd.out_load = 1'b0;
              cmd.clr_i    = 1'b1;
            end
            OP_SORT: begin
              cmd.out_load = st.size_lt2;
              cmd.clr_i    = !st.size_lt2;
            end
            OP_SEARCH: begin
              cmd.out_load = 1'b0;
              cmd.clr_i    = 1'b1;
              cmd.clr_n    = 1'b1;
            end
            default: cmd.out_load = 1'b1;
          endcase
        end
      end
      S_EMIT: cmd.out_load = 1'b0;
      S_DEL_RD: begin
        if (st.i_lt_size) begin
          cmd.rd_en = 1'b1;
        end else begin
          cmd.out_load = 1'b1;
          cmd.osel     = OSEL_MISS;
          cmd.ostat    = ST_NOTFOUND;
        end
      end
      S_DEL_CHK: begin
        cmd.set_j_i = st.match;
        cmd.inc_i   = !st.match;
      end
      S_SH_RD: begin
        if (st.j1_lt_size) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RSEL_J1;
        end else begin
          cmd.shrink   = 1'b1;
          cmd.out_load = 1'b1;
          cmd.osel     = OSEL_KEY;
        end
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.inc_j    = 1'b1;
      end
      S_RD_RD: cmd.rd_en = 1'b1;
      S_RD_EM: begin
        cmd.out_load = 1'b1;
        cmd.osel     = OSEL_READ;
        cmd.inc_i    = 1'b1;
      end
      S_SO_LDA: cmd.rd_en = 1'b1;
      S_SO_A: begin
        cmd.sort_ld_a = 1'b1;
        cmd.set_j_i1  = 1'b1;
      end
      S_SO_RD: begin
        if (st.j_lt_size) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RSEL_J;
        end else begin
          cmd.sort_wr_i = 1'b1;
          cmd.inc_i     = 1'b1;
          cmd.out_load  = !st.i_more;
        end
      end
      S_SO_CMP: begin
        cmd.sort_step = 1'b1;
        cmd.inc_j     = 1'b1;
      end
      S_SC_RD: begin
        if (st.i_lt_size) begin
          cmd.rd_en = 1'b1;
        end else if (st.n_zero) begin
          cmd.out_load = 1'b1;
          cmd.osel     = OSEL_MISS;
          cmd.ostat    = ST_NOTFOUND;
        end else begin
          cmd.clr_i = 1'b1;
          cmd.clr_k = 1'b1;
        end
      end
      S_SC_CHK: begin
        cmd.cnt_step = 1'b1;
        cmd.inc_i    = 1'b1;
      end
      S_SE_RD: cmd.rd_en = 1'b1;
      S_SE_CHK: begin
        cmd.inc_i    = 1'b1;
        cmd.out_load = st.match;
        cmd.inc_k    = st.match;
        cmd.osel     = OSEL_MATCH;
      end
      default: cmd.out_load = 1'b0;
    endcase
  end

endmodule

// ----- src/ate_dp.sv -----
// ate_dp: table memory, counters, captured transaction and result register.
// Depends on ate_pkg; takes cmd_t from ate_ctrl and returns stat_t.
`timescale 1ns / 1ps

module ate_dp
  import ate_pkg::*;
#(
  parameter int DEPTH = ATE_DEPTH
)(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    st,
  input  logic [OP_W-1:0]          in_op,
  input  logic [CNT_W-1:0]         in_count,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_descending,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [IDX_W-1:0]         out_entry_index,
  output logic signed [DATA_W-1:0] out_entry_value,
  output logic [MCNT_W-1:0]        out_match_count,
  output logic                     out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Captured transaction
  op_t                     op_r;
  logic [CNT_W-1:0]        count_r, pos_r;
  logic signed [DATA_W-1:0] key_r;
  logic                    desc_r;

  // Table state and walk counters
  logic [CW-1:0]           size_r, fp_r, i_r, j_r, n_r, k_r;
  logic signed [DATA_W-1:0] a_r, rd_data_r;
  logic [DATA_W-1:0]       mem [DEPTH];
  logic [DEPTH-1:0]        vld_r;

  logic                    we;
  logic [AW-1:0]           wa, ra;
  logic [DATA_W-1:0]       wd;
  logic                    swap;
  logic [CW:0]             size_x, i_x, j_x, n_x, k_x;

  // Next result fields
  logic [STAT_W-1:0]        out_status_nxt;
  logic [IDX_W-1:0]         out_entry_index_nxt;
  logic signed [DATA_W-1:0] out_entry_value_nxt;
  logic [MCNT_W-1:0]        out_match_count_nxt;
  logic                     out_last_nxt;

  assign size_x = (CW+1)'(size_r);
  assign i_x    = (CW+1)'(i_r);
  assign j_x    = (CW+1)'(j_r);
  assign n_x    = (CW+1)'(n_r);
  assign k_x    = (CW+1)'(k_r);

  // Status toward the controller
  always_comb begin
    st.op         = op_r;
    st.count_ok   = (count_r != '0) && ({1'b0, count_r} <= (CNT_W+1)'(DEPTH));
    st.size_zero  = (size_r == '0);
    st.size_lt2   = (size_x < (CW+1)'(2));
    st.fp_full    = (fp_r >= size_r);
    st.pos_bad    = ({1'b0, pos_r} >= (CNT_W+1)'(size_r));
    st.i_lt_size  = (i_r < size_r);
    st.i_last     = (i_x + (CW+1)'(1) == size_x);
    st.i_more     = (i_x + (CW+1)'(2) < size_x);
    st.j_lt_size  = (j_r < size_r);
    st.j1_lt_size = (j_x + (CW+1)'(1) < size_x);
    st.match      = (rd_data_r == key_r);
    st.n_zero     = (n_r == '0);
    st.k_last     = (k_x + (CW+1)'(1) == n_x);
  end

  // Sort exchange test against the held element
  assign swap = desc_r ? (a_r < rd_data_r) : (a_r > rd_data_r);

  // Write port select
  always_comb begin
    we = 1'b0;
    wa = i_r[AW-1:0];
    wd = key_r;
    priority if (cmd.fill_wr) begin
      we = 1'b1;
      wa = fp_r[AW-1:0];
    end else if (cmd.upd_wr) begin
      we = 1'b1;
      wa = pos_r[AW-1:0];
    end else if (cmd.shift_wr) begin
      we = 1'b1;
      wa = j_r[AW-1:0];
      wd = rd_data_r;
    end else if (cmd.sort_step) begin
      we = swap;
      wa = j_r[AW-1:0];
      wd = a_r;
    end else if (cmd.sort_wr_i) begin
      we = 1'b1;
      wd = a_r;
    end
  end

  // Read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RSEL_I:  ra = i_r[AW-1:0];
      RSEL_J:  ra = j_r[AW-1:0];
      RSEL_J1: ra = AW'(j_x + (CW+1)'(1));
      default: ra = i_r[AW-1:0];
    endcase
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd_en) rd_data_r <= vld_r[ra] ? mem[ra] : '0;
  end

  // Entry valid bits; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (we) vld_r[wa] <= 1'b1;
  end

  // Captured transaction fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(in_op);
      count_r <= in_count;
      pos_r   <= in_position;
      key_r   <= in_value;
      desc_r  <= in_descending;
    end
    if (cmd.sort_ld_a) a_r <= rd_data_r;
    else if (cmd.sort_step && swap) a_r <= rd_data_r;
  end

  // Size and fill pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      fp_r   <= '0;
    end else if (cmd.load_start) begin
      size_r <= st.count_ok ? CW'(count_r) : '0;
      fp_r   <= '0;
    end else if (cmd.fill_wr) begin
      fp_r <= fp_r + CW'(1);
    end else if (cmd.shrink) begin
      size_r <= size_r - CW'(1);
      if (fp_r > size_r - CW'(1)) fp_r <= size_r - CW'(1);
    end
  end

  // Walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      n_r <= '0;
      k_r <= '0;
    end else begin
      if (cmd.clr_i) i_r <= '0;
      else if (cmd.inc_i) i_r <= i_r + CW'(1);
      if (cmd.set_j_i) j_r <= i_r;
      else if (cmd.set_j_i1) j_r <= i_r + CW'(1);
      else if (cmd.inc_j) j_r <= j_r + CW'(1);
      if (cmd.clr_n) n_r <= '0;
      else if (cmd.cnt_step && st.match) n_r <= n_r + CW'(1);
      if (cmd.clr_k) k_r <= '0;
      else if (cmd.inc_k) k_r <= k_r + CW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result field select
  always_comb begin
    out_status_nxt      = cmd.ostat;
    out_entry_index_nxt = '0;
    out_entry_value_nxt = '0;
    out_match_count_nxt = '0;
    out_last_nxt        = 1'b1;
    unique case (cmd.osel)
      OSEL_PLAIN: out_last_nxt = 1'b1;
      OSEL_MISS:  out_entry_value_nxt = key_r;
      OSEL_KEY: begin
        out_entry_index_nxt = IDX_W'(i_r[AW-1:0]);
        out_entry_value_nxt = key_r;
      end
      OSEL_READ: begin
        out_entry_index_nxt = IDX_W'(i_r[AW-1:0]);
        out_entry_value_nxt = rd_data_r;
        out_last_nxt        = st.i_last;
      end
      OSEL_MATCH: begin
        out_entry_index_nxt = IDX_W'(i_r[AW-1:0]);
        out_entry_value_nxt = key_r;
        out_match_count_nxt = MCNT_W'(n_r);
        out_last_nxt        = st.k_last;
      end
      default: out_last_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status      <= out_status_nxt;
      out_entry_index <= out_entry_index_nxt;
      out_entry_value <= out_entry_value_nxt;
      out_match_count <= out_match_count_nxt;
      out_last        <= out_last_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CW'(DEPTH)) else $error("table size above depth");
  a_fp_range: assert property (@(posedge clk) disable iff (!rst_n)
    fp_r <= size_r) else $error("fill pointer beyond size");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid) else $error("result loaded over pending one");
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.rd_sel == RSEL_I) |-> (i_r < size_r))
    else $error("read beyond size");
`endif

endmodule

// ----- src/array_table_engine_core.sv -----
// Array table engine: one transaction at a time. Delete and search walk the
// table entry by entry (search walks it twice, once to count matches and once
// to emit them), read-out emits one result per entry, and sort compares and
// exchanges entries; the table memory has a registered read. Each result waits
// in the output register until taken. Synchronous active-low reset clears size,
// fill pointer, valid bits, walk counters, result valid flag and control.
// Depends on ate_pkg, ate_ctrl and ate_dp.
`timescale 1ns / 1ps

module array_table_engine_core
  import ate_pkg::*;
#(
  parameter int DEPTH = ATE_DEPTH
)(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_op,
  input  logic [CNT_W-1:0]         in_count,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_descending,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic [IDX_W-1:0]         out_entry_index,
  output logic signed [DATA_W-1:0] out_entry_value,
  output logic [MCNT_W-1:0]        out_match_count,
  output logic                     out_last
);

  cmd_t  cmd;
  stat_t st;

  ate_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ate_dp #(.DEPTH(DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_op           (in_op),
    .in_count        (in_count),
    .in_position     (in_position),
    .in_value        (in_value),
    .in_descending   (in_descending),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_entry_value (out_entry_value),
    .out_match_count (out_match_count),
    .out_last        (out_last)
  );

endmodule
